[rtl/srarq_pkg.sv]
// shared types, codes and the window helper for the selective-repeat arq controller
package srarq_pkg;

  localparam int SEQ_W  = 5;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] WINDOW = 5'd16;
  localparam logic [SEQ_W-1:0] WINDOW_SEQ = 5'd16;

  // request types on the input channel
  localparam logic [2:0] REQ_PACKET  = 3'd0;
  localparam logic [2:0] REQ_PHYS    = 3'd1;
  localparam logic [2:0] REQ_FRAME   = 3'd2;
  localparam logic [2:0] REQ_DATA_TO = 3'd3;
  localparam logic [2:0] REQ_ACK_TO  = 3'd4;

  // received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // command actions
  localparam logic [2:0] ACT_STATUS  = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_RESEND  = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_NAK     = 3'd4;
  localparam logic [2:0] ACT_STORE   = 3'd5;
  localparam logic [2:0] ACT_DELIVER = 3'd6;
  localparam logic [2:0] ACT_STOP    = 3'd7;

  // ack timer commands
  localparam logic [1:0] ATM_KEEP  = 2'd0;
  localparam logic [1:0] ATM_START = 2'd1;
  localparam logic [1:0] ATM_STOP  = 2'd2;

  // classified operations passed from front to back
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_SEND      = 3'd1;
  localparam logic [2:0] OP_PHYS      = 3'd2;
  localparam logic [2:0] OP_FRAME_BAD = 3'd3;
  localparam logic [2:0] OP_FRAME_DAT = 3'd4;
  localparam logic [2:0] OP_FRAME_ACK = 3'd5;
  localparam logic [2:0] OP_FRAME_NAK = 3'd6;
  localparam logic [2:0] OP_TIMEOUT   = 3'd7;
  // ack timeout travels as its own flag on OP_NONE

  typedef struct packed {
    logic [2:0]       op;
    logic             ack_to;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [SEQ_W-1:0] tslot;
  } ev_t;

  typedef struct packed {
    logic [CNT_W-1:0] buffered_count;
    logic             busy;
  } back_stat_t;

  // b lies in the circular range [a, c)
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

[rtl/srarq_front.sv]
// request classification and two-entry queue toward the command sequencer
module srarq_front import srarq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_req_type,
  input  logic             in_frame_good,
  input  logic [1:0]       in_frame_kind,
  input  logic [SEQ_W-1:0] in_frame_seq,
  input  logic [SEQ_W-1:0] in_frame_ack,
  input  logic [SEQ_W-1:0] in_timeout_slot,
  output logic             q_valid,
  output ev_t              q_ev,
  input  logic             q_pop
);

  ev_t        q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  ev_t        ev;
  logic       push;

  always_comb begin
    ev = '0;
    ev.seq   = in_frame_seq;
    ev.ack   = in_frame_ack;
    ev.tslot = in_timeout_slot;
    case (in_req_type)
      REQ_PACKET:  ev.op = OP_SEND;
      REQ_PHYS:    ev.op = OP_PHYS;
      REQ_DATA_TO: ev.op = OP_TIMEOUT;
      REQ_ACK_TO: begin
        ev.op     = OP_NONE;
        ev.ack_to = 1'b1;
      end
      REQ_FRAME: begin
        if (!in_frame_good) ev.op = OP_FRAME_BAD;
        else if (in_frame_kind == KIND_DATA) ev.op = OP_FRAME_DAT;
        else if (in_frame_kind == KIND_NAK) ev.op = OP_FRAME_NAK;
        else ev.op = OP_FRAME_ACK;   // unknown kind acts as an ack
      end
      default:     ev.op = OP_NONE;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_ev     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= ev;
  end

endmodule

[rtl/srarq_back.sv]
// window state and command sequencer with registered command output
module srarq_back import srarq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ev_t               q_ev,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [SEQ_W-1:0]  out_ack,
  output logic [SLOT_W-1:0] out_buffer_slot,
  output logic              out_start_data_timer,
  output logic [1:0]        out_ack_timer_cmd,
  output logic              out_network_enable,
  output logic              out_last,
  output back_stat_t        stat
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FIRST   = 3'd1;
  localparam logic [2:0] S_STORE   = 3'd2;
  localparam logic [2:0] S_DELIVER = 3'd3;
  localparam logic [2:0] S_NAKRES  = 3'd4;
  localparam logic [2:0] S_ACKLOOP = 3'd5;
  localparam logic [2:0] S_STATUS  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  ev_t               cur_r, cur_nxt;
  logic [SEQ_W-1:0]  nts_r, nts_nxt;
  logic [SEQ_W-1:0]  re_r, re_nxt;
  logic [SEQ_W-1:0]  ou_r, ou_nxt;
  logic [SEQ_W-1:0]  ru_r, ru_nxt;
  logic [CNT_W-1:0]  bc_r, bc_nxt;
  logic [WINDOW-1:0] map_r, map_nxt;
  logic              nak_ok_r, nak_ok_nxt;
  logic              phys_r, phys_nxt;

  logic              vld_r, vld_nxt;
  logic [2:0]        act_r, act_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [SEQ_W-1:0]  ack_r, ack_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              start_r, start_nxt;
  logic [1:0]        atm_r, atm_nxt;
  logic              ne_r, ne_nxt;
  logic              last_r, last_nxt;

  logic              out_free;
  logic              emit;
  logic [SEQ_W-1:0]  ackv;
  logic [SEQ_W-1:0]  tsl;
  logic [SEQ_W-1:0]  nak_seq;

  assign out_free = !vld_r || !out_stall;
  assign ackv     = re_r - 5'd1;
  assign tsl      = in_window(ou_r, cur_r.tslot, nts_r) ? cur_r.tslot
                                                        : cur_r.tslot + WINDOW_SEQ;
  assign nak_seq  = cur_r.ack + 5'd1;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    nts_nxt    = nts_r;
    re_nxt     = re_r;
    ou_nxt     = ou_r;
    ru_nxt     = ru_r;
    bc_nxt     = bc_r;
    map_nxt    = map_r;
    nak_ok_nxt = nak_ok_r;
    phys_nxt   = phys_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    act_nxt    = ACT_STATUS;
    seq_nxt    = '0;
    ack_nxt    = '0;
    slot_nxt   = '0;
    start_nxt  = 1'b0;
    atm_nxt    = ATM_KEEP;
    ne_nxt     = 1'b0;
    last_nxt   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_ev;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        case (cur_r.op)
          OP_SEND: begin
            if (bc_r < WINDOW) begin
              emit      = 1'b1;
              act_nxt   = ACT_SEND;
              seq_nxt   = nts_r;
              ack_nxt   = ackv;
              slot_nxt  = nts_r[SLOT_W-1:0];
              start_nxt = 1'b1;
              if (out_free) begin
                nts_nxt   = nts_r + 5'd1;
                bc_nxt    = bc_r + 5'd1;
                state_nxt = S_STATUS;
              end
            end else begin
              state_nxt = S_STATUS;
            end
          end
          OP_PHYS: begin
            phys_nxt  = 1'b1;
            state_nxt = S_STATUS;
          end
          OP_TIMEOUT: begin
            emit      = 1'b1;
            act_nxt   = ACT_RESEND;
            seq_nxt   = tsl;
            ack_nxt   = ackv;
            slot_nxt  = tsl[SLOT_W-1:0];
            start_nxt = 1'b1;
            atm_nxt   = ATM_STOP;
            if (out_free) state_nxt = S_STATUS;
          end
          OP_FRAME_BAD: begin
            if (nak_ok_r) begin
              emit    = 1'b1;
              act_nxt = ACT_NAK;
              ack_nxt = ackv;
              atm_nxt = ATM_STOP;
              if (out_free) begin
                nak_ok_nxt = 1'b0;
                state_nxt  = S_STATUS;
              end
            end else begin
              state_nxt = S_STATUS;
            end
          end
          OP_FRAME_DAT: begin
            emit = 1'b1;
            if (cur_r.seq != re_r && nak_ok_r) begin
              act_nxt = ACT_NAK;
              ack_nxt = ackv;
              atm_nxt = ATM_STOP;
              if (out_free) nak_ok_nxt = 1'b0;
            end else begin
              atm_nxt = ATM_START;
            end
            if (out_free) state_nxt = S_STORE;
          end
          OP_FRAME_NAK: state_nxt = S_NAKRES;
          OP_FRAME_ACK: state_nxt = S_ACKLOOP;
          default: begin
            // ack timeout sends a bare ack, anything else only the status
            if (cur_r.ack_to) begin
              emit    = 1'b1;
              act_nxt = ACT_ACK;
              ack_nxt = ackv;
              atm_nxt = ATM_STOP;
              if (out_free) state_nxt = S_STATUS;
            end else begin
              state_nxt = S_STATUS;
            end
          end
        endcase
      end
      S_STORE: begin
        if (in_window(re_r, cur_r.seq, ru_r) && !map_r[cur_r.seq[SLOT_W-1:0]]) begin
          emit     = 1'b1;
          act_nxt  = ACT_STORE;
          seq_nxt  = cur_r.seq;
          slot_nxt = cur_r.seq[SLOT_W-1:0];
          if (out_free) begin
            map_nxt[cur_r.seq[SLOT_W-1:0]] = 1'b1;
            state_nxt = S_DELIVER;
          end
        end else begin
          state_nxt = S_ACKLOOP;
        end
      end
      S_DELIVER: begin
        // hand over in-order frames while the next expected slot is filled
        if (map_r[re_r[SLOT_W-1:0]]) begin
          emit     = 1'b1;
          act_nxt  = ACT_DELIVER;
          seq_nxt  = re_r;
          slot_nxt = re_r[SLOT_W-1:0];
          atm_nxt  = ATM_START;
          if (out_free) begin
            map_nxt[re_r[SLOT_W-1:0]] = 1'b0;
            nak_ok_nxt = 1'b1;
            re_nxt     = re_r + 5'd1;
            ru_nxt     = ru_r + 5'd1;
          end
        end else begin
          state_nxt = S_ACKLOOP;
        end
      end
      S_NAKRES: begin
        if (in_window(ou_r, nak_seq, nts_r)) begin
          emit      = 1'b1;
          act_nxt   = ACT_RESEND;
          seq_nxt   = nak_seq;
          ack_nxt   = ackv;
          slot_nxt  = nak_seq[SLOT_W-1:0];
          start_nxt = 1'b1;
          atm_nxt   = ATM_STOP;
          if (out_free) state_nxt = S_ACKLOOP;
        end else begin
          state_nxt = S_ACKLOOP;
        end
      end
      S_ACKLOOP: begin
        // cumulative ack releases frames one per command
        if (in_window(ou_r, cur_r.ack, nts_r)) begin
          emit     = 1'b1;
          act_nxt  = ACT_STOP;
          slot_nxt = ou_r[SLOT_W-1:0];
          if (out_free) begin
            if (bc_r != '0) bc_nxt = bc_r - 5'd1;
            ou_nxt = ou_r + 5'd1;
          end
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        emit     = 1'b1;
        ne_nxt   = (bc_r < WINDOW) && phys_r;
        last_nxt = 1'b1;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit && out_free) vld_nxt = 1'b1;
    else if (!out_stall) vld_nxt = 1'b0;
    else vld_nxt = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      nts_r    <= '0;
      re_r     <= '0;
      ou_r     <= '0;
      ru_r     <= WINDOW_SEQ;
      bc_r     <= '0;
      map_r    <= '0;
      nak_ok_r <= 1'b1;
      phys_r   <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nts_r    <= nts_nxt;
      re_r     <= re_nxt;
      ou_r     <= ou_nxt;
      ru_r     <= ru_nxt;
      bc_r     <= bc_nxt;
      map_r    <= map_nxt;
      nak_ok_r <= nak_ok_nxt;
      phys_r   <= phys_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit && out_free) begin
      act_r   <= act_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      slot_r  <= slot_nxt;
      start_r <= start_nxt;
      atm_r   <= atm_nxt;
      ne_r    <= ne_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid            = vld_r;
  assign out_action           = act_r;
  assign out_seq              = seq_r;
  assign out_ack              = ack_r;
  assign out_buffer_slot      = slot_r;
  assign out_start_data_timer = start_r;
  assign out_ack_timer_cmd    = atm_r;
  assign out_network_enable   = ne_r;
  assign out_last             = last_r;
  assign stat.buffered_count  = bc_r;
  assign stat.busy            = (state_r != S_IDLE);

endmodule

[rtl/selective_repeat_arq_controller_top.sv]
// Selective-repeat ARQ controller: sequence and window logic of a sliding-window link.
// Input channel (in_valid / in_stall) takes one event per request: packet ready,
// physical layer ready, frame received, data timeout or ack timeout, with the
// received frame's check result, kind, sequence and ack numbers and the timer slot.
// Result channel (out_valid / out_stall) returns a run of commands per event; the
// run always ends with a status command that has out_last set and carries the
// network-layer enable.
// A two-entry request queue sits in front of the command sequencer, so up to two
// further requests are taken while a run is still being emitted.
// With the sequencer idle, a taken request passes through the queue entry and the
// sequencer's event register before its first command is registered onto out_valid.
// The sequencer walks deliver and release loops one sequence number per cycle while
// out_stall is low, and each loop exit passes through a state that emits no command;
// it pops the next request only from idle, after the run's status command.
// Reset (rst_n low, synchronous) empties the queue and output register and puts
// the windows at their start: send and receive at 0, receive upper edge 16,
// nothing buffered, all slots empty, nak allowed, physical layer not ready.
// While out_stall is high the pending command holds and the sequencer waits to emit the next one.
module selective_repeat_arq_controller_top import srarq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic              in_frame_good,
  input  logic [1:0]        in_frame_kind,
  input  logic [SEQ_W-1:0]  in_frame_seq,
  input  logic [SEQ_W-1:0]  in_frame_ack,
  input  logic [SEQ_W-1:0]  in_timeout_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [SEQ_W-1:0]  out_ack,
  output logic [SLOT_W-1:0] out_buffer_slot,
  output logic              out_start_data_timer,
  output logic [1:0]        out_ack_timer_cmd,
  output logic              out_network_enable,
  output logic              out_last
);

  logic       q_valid;
  ev_t        q_ev;
  logic       q_pop;
  back_stat_t stat;

  srarq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_frame_good   (in_frame_good),
    .in_frame_kind   (in_frame_kind),
    .in_frame_seq    (in_frame_seq),
    .in_frame_ack    (in_frame_ack),
    .in_timeout_slot (in_timeout_slot),
    .q_valid         (q_valid),
    .q_ev            (q_ev),
    .q_pop           (q_pop)
  );

  srarq_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_ev                 (q_ev),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_seq              (out_seq),
    .out_ack              (out_ack),
    .out_buffer_slot      (out_buffer_slot),
    .out_start_data_timer (out_start_data_timer),
    .out_ack_timer_cmd    (out_ack_timer_cmd),
    .out_network_enable   (out_network_enable),
    .out_last             (out_last),
    .stat                 (stat)
  );

  // send window never holds more than a window of frames
  a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.buffered_count <= WINDOW)
    else $error("buffered count above window");

  // the final command of a run is always the status command
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_action == ACT_STATUS)
    else $error("last command is not status");

  // network enable only rides on the final command
  a_ne_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_network_enable |-> out_last)
    else $error("network enable off the last command");

  // data timer starts only with a data transmission
  a_timer_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_data_timer |->
      (out_action == ACT_SEND || out_action == ACT_RESEND))
    else $error("data timer started without a send");

  // a run still in progress keeps the sequencer busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> stat.busy)
    else $error("sequencer idle in the middle of a run");

endmodule

[tb/srarq_checker.sv]
// command-run predictor and scoreboard for the selective-repeat arq controller
module srarq_checker import srarq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic              in_frame_good,
  input  logic [1:0]        in_frame_kind,
  input  logic [SEQ_W-1:0]  in_frame_seq,
  input  logic [SEQ_W-1:0]  in_frame_ack,
  input  logic [SEQ_W-1:0]  in_timeout_slot,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_action,
  input  logic [SEQ_W-1:0]  out_seq,
  input  logic [SEQ_W-1:0]  out_ack,
  input  logic [SLOT_W-1:0] out_buffer_slot,
  input  logic              out_start_data_timer,
  input  logic [1:0]        out_ack_timer_cmd,
  input  logic              out_network_enable,
  input  logic              out_last,
  output int                fail_count,
  output int                pending_cmds
);

  typedef struct packed {
    logic [2:0]        action;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [SLOT_W-1:0] slot;
    logic              start;
    logic [1:0]        atm;
    logic              nen;
    logic              last;
  } cmd_t;

  cmd_t cmd_q[$];

  logic [SEQ_W-1:0] p_next, p_rexp, p_oldest, p_rupper;
  logic [CNT_W-1:0] p_count;
  logic [15:0]      p_arrived;
  logic             p_nak_ok, p_phys;

  function automatic logic wrap_in(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                   logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  task automatic push_cmd(logic [2:0] act, logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
                          logic [SLOT_W-1:0] sl, logic st, logic [1:0] atm);
    cmd_t c;
    c = '{act, s, a, sl, st, atm, 1'b0, 1'b0};
    cmd_q.push_back(c);
  endtask

  task automatic predict_event(logic [2:0] req, logic good, logic [1:0] kind,
                               logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                               logic [SEQ_W-1:0] tslot);
    logic [SEQ_W-1:0] t, r;
    cmd_t c;
    case (req)
      REQ_PACKET: begin
        if (p_count < WINDOW) begin
          p_count++;
          push_cmd(ACT_SEND, p_next, p_rexp - 1'b1, p_next[3:0], 1'b1, ATM_KEEP);
          p_next++;
        end
      end
      REQ_PHYS: p_phys = 1'b1;
      REQ_FRAME: begin
        if (!good) begin
          if (p_nak_ok) begin
            push_cmd(ACT_NAK, '0, p_rexp - 1'b1, '0, 1'b0, ATM_STOP);
            p_nak_ok = 1'b0;
          end
        end else begin
          if (kind == KIND_DATA) begin
            if (seq != p_rexp && p_nak_ok) begin
              push_cmd(ACT_NAK, '0, p_rexp - 1'b1, '0, 1'b0, ATM_STOP);
              p_nak_ok = 1'b0;
            end else push_cmd(ACT_STATUS, '0, '0, '0, 1'b0, ATM_START);
            if (wrap_in(p_rexp, seq, p_rupper) && !p_arrived[seq[3:0]]) begin
              p_arrived[seq[3:0]] = 1'b1;
              push_cmd(ACT_STORE, seq, '0, seq[3:0], 1'b0, ATM_KEEP);
              while (p_arrived[p_rexp[3:0]]) begin
                push_cmd(ACT_DELIVER, p_rexp, '0, p_rexp[3:0], 1'b0, ATM_START);
                p_nak_ok = 1'b1;
                p_arrived[p_rexp[3:0]] = 1'b0;
                p_rexp++;
                p_rupper++;
              end
            end
          end
          if (kind == KIND_NAK) begin
            r = ack + 1'b1;
            if (wrap_in(p_oldest, r, p_next))
              push_cmd(ACT_RESEND, r, p_rexp - 1'b1, r[3:0], 1'b1, ATM_STOP);
          end
          while (wrap_in(p_oldest, ack, p_next)) begin
            if (p_count > 0) p_count--;
            push_cmd(ACT_STOP, '0, '0, p_oldest[3:0], 1'b0, ATM_KEEP);
            p_oldest++;
          end
        end
      end
      REQ_DATA_TO: begin
        t = tslot;
        if (!wrap_in(p_oldest, t, p_next)) t = t + WINDOW_SEQ;
        push_cmd(ACT_RESEND, t, p_rexp - 1'b1, t[3:0], 1'b1, ATM_STOP);
      end
      REQ_ACK_TO: push_cmd(ACT_ACK, '0, p_rexp - 1'b1, '0, 1'b0, ATM_STOP);
      default: ;
    endcase
    c = '{ACT_STATUS, '0, '0, '0, 1'b0, ATM_KEEP, (p_count < WINDOW) && p_phys, 1'b1};
    cmd_q.push_back(c);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_t e;
    if (!rst_n) begin
      p_next = '0; p_rexp = '0; p_oldest = '0; p_rupper = WINDOW_SEQ;
      p_count = '0; p_arrived = '0; p_nak_ok = 1'b1; p_phys = 1'b0;
      fail_count = 0;
      cmd_q.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_event(in_req_type, in_frame_good, in_frame_kind, in_frame_seq,
                      in_frame_ack, in_timeout_slot);
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          $error("unexpected command action %0d", out_action);
          fail_count++;
        end else begin
          e = cmd_q.pop_front();
          check_field("action", e.action, out_action);
          check_field("seq", e.seq, out_seq);
          check_field("ack", e.ack, out_ack);
          check_field("buffer_slot", e.slot, out_buffer_slot);
          check_field("start_data_timer", e.start, out_start_data_timer);
          check_field("ack_timer_cmd", e.atm, out_ack_timer_cmd);
          check_field("network_enable", e.nen, out_network_enable);
          check_field("last", e.last, out_last);
        end
      end
    end
    pending_cmds = cmd_q.size();
  end

endmodule

[tb/tb.sv]
// stimulus and verdict for the selective-repeat arq controller
module tb import srarq_pkg::*;;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [2:0] in_req_type = '0;
  logic in_frame_good = 1'b0;
  logic [1:0] in_frame_kind = '0;
  logic [SEQ_W-1:0] in_frame_seq = '0, in_frame_ack = '0, in_timeout_slot = '0;
  logic [2:0] out_action;
  logic [SEQ_W-1:0] out_seq, out_ack;
  logic [SLOT_W-1:0] out_buffer_slot;
  logic out_start_data_timer, out_network_enable, out_last;
  logic [1:0] out_ack_timer_cmd;
  int fail_count, pending_cmds, cycles = 0;
  logic hold_rx = 1'b0;
  logic [SEQ_W-1:0] sent_hi = '0, rx_seq = '0;

  always #5 clk = ~clk;

  selective_repeat_arq_controller_top u_top (.*);

  srarq_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  // random receiver stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 5) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
  end

  initial begin
    repeat (120) @(posedge clk);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end

  task automatic send_req(logic [2:0] rq, logic g, logic [1:0] k, logic [SEQ_W-1:0] s,
                          logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] t);
    in_valid <= 1'b1;
    in_req_type <= rq; in_frame_good <= g; in_frame_kind <= k;
    in_frame_seq <= s; in_frame_ack <= a; in_timeout_slot <= t;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0 && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int r;
    logic [2:0] rq;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: status-only, phys, sends, acks, naks, bad frames, timeouts
    send_req(REQ_PACKET, 0, KIND_DATA, 0, 0, 0);
    send_req(REQ_PHYS, 0, KIND_DATA, 0, 0, 0);
    send_req(3'd5, 1, 2'd3, 31, 31, 31);
    send_req(3'd7, 0, 0, 0, 0, 0);
    send_req(REQ_ACK_TO, 1, KIND_ACK, 0, 0, 0);
    send_req(REQ_DATA_TO, 0, KIND_DATA, 0, 0, 31);
    send_req(REQ_DATA_TO, 0, KIND_DATA, 0, 0, 0);
    send_req(REQ_FRAME, 0, KIND_DATA, 3, 3, 0);
    send_req(REQ_FRAME, 0, KIND_DATA, 3, 3, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 0, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 5, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 2, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 3, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 4, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 1, 31, 0);
    send_req(REQ_FRAME, 1, KIND_DATA, 31, 31, 0);
    // fill the send window, then overfill it (ignored)
    repeat (17) send_req(REQ_PACKET, 0, 0, 0, 0, 0);
    send_req(REQ_FRAME, 1, KIND_NAK, 0, 4, 0);
    send_req(REQ_FRAME, 1, KIND_NAK, 0, 20, 0);
    send_req(REQ_DATA_TO, 0, 0, 0, 0, 7);
    send_req(REQ_DATA_TO, 0, 0, 0, 0, 25);
    send_req(REQ_FRAME, 1, 2'd3, 0, 15, 0);
    send_req(REQ_FRAME, 1, KIND_ACK, 0, 31, 0);
    rx_seq = 5'd6; sent_hi = 5'd16;
    for (int i = 0; i < 140; i++) begin
      idle_gap();
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_req(REQ_PACKET, 1'($urandom), 2'($urandom), SEQ_W'($urandom),
                 SEQ_W'($urandom), SEQ_W'($urandom));
        sent_hi++;
      end else if (r < 55) begin
        // data frames near the receive window, mostly in order
        send_req(REQ_FRAME, $urandom_range(0, 9) != 0, KIND_DATA,
                 SEQ_W'(rx_seq + $urandom_range(0, 3) -
                        ($urandom_range(0, 5) == 0 ? 8 : 0)),
                 SEQ_W'($urandom), SEQ_W'($urandom));
        rx_seq++;
      end else if (r < 70) begin
        send_req(REQ_FRAME, $urandom_range(0, 7) != 0, KIND_ACK, SEQ_W'($urandom),
                 SEQ_W'(sent_hi - $urandom_range(1, 8)), SEQ_W'($urandom));
      end else if (r < 80) begin
        send_req(REQ_FRAME, 1, KIND_NAK, SEQ_W'($urandom),
                 SEQ_W'(sent_hi - $urandom_range(1, 6)), SEQ_W'($urandom));
      end else if (r < 88) begin
        send_req(REQ_DATA_TO, 1'($urandom), 2'($urandom), SEQ_W'($urandom),
                 SEQ_W'($urandom), SEQ_W'($urandom));
      end else if (r < 94) begin
        send_req(REQ_ACK_TO, 1'($urandom), 2'($urandom), SEQ_W'($urandom),
                 SEQ_W'($urandom), SEQ_W'($urandom));
      end else begin
        rq = 3'($urandom);
        send_req(rq, 1'($urandom), 2'($urandom), SEQ_W'($urandom),
                 SEQ_W'($urandom), SEQ_W'($urandom));
      end
    end
    in_valid <= 1'b0;
    while (pending_cmds != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_cmds == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[selective_repeat_arq_controller_top.f]
rtl/srarq_pkg.sv
rtl/srarq_front.sv
rtl/srarq_back.sv
rtl/selective_repeat_arq_controller_top.sv
tb/srarq_checker.sv
tb/tb.sv
